// ----- rtl/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg: shared types, constants and functions of the ray/segment test
// Fixed-point widths, the sine polynomial coefficients, the beat handed
// from the front to the back through the queue, and one divider step.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int COORD_W      = 24;
    localparam int HEADING_BITS = 12;
    localparam int HEAD_W       = 12;
    localparam int CFG_W        = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int DIR_W        = 16;
    localparam int DIFF_W       = 25;
    localparam int DET_W        = 41;
    localparam int UN_W         = 51;
    localparam int MAG_W        = 40;
    localparam int REM_W        = 42;
    localparam int FIFO_DEPTH   = 16;
    localparam int FIFO_AW      = 4;
    localparam int SINE_SHIFT   = 16 - (HEADING_BITS - 2);

    localparam int SIN_C1  = 102944;
    localparam int SIN_C3  = 42334;
    localparam int SIN_C5  = 5223;
    localparam int SIN_C7  = 307;
    localparam int DIR_ONE = 16384;

    localparam logic signed [26:0] PT_MAX = 27'sd8388607;
    localparam logic signed [26:0] PT_MIN = -27'sd8388608;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_HEADING  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // one classified segment, waiting for the divider
    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [DIFF_W-1:0]         ax;
        logic [DIFF_W-1:0]         ay;
        logic                      negx;
        logic                      negy;
        logic [MAG_W-1:0]          b;
        logic [MAG_W-1:0]          c;
    } qitem_t;

    typedef struct packed {
        logic [MAG_W-1:0] r;
        logic [1:0]       inc;
    } dstep_t;

    // one bit of floor(a*b/c) with b < c: remainder stays below c
    function automatic dstep_t div_step(input logic [MAG_W-1:0] r,
                                        input logic             bit_in,
                                        input logic [MAG_W-1:0] b,
                                        input logic [MAG_W-1:0] c);
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] c1;
        logic [REM_W-1:0] c2;
        dstep_t           res;
        c1 = {2'b00, c};
        c2 = {1'b0, c, 1'b0};
        t  = {1'b0, r, 1'b0} + (bit_in ? {2'b00, b} : {REM_W{1'b0}});
        priority if (t >= c2)
        begin
            res.r   = MAG_W'(t - c2);
            res.inc = 2'd2;
        end
        else if (t >= c1)
        begin
            res.r   = MAG_W'(t - c1);
            res.inc = 2'd1;
        end
        else
        begin
            res.r   = MAG_W'(t);
            res.inc = 2'd0;
        end
        return res;
    endfunction

endpackage

// ----- rtl/rsi_front.sv -----
// ----------------------------------------------------------------------------
// rsi_front: direction, determinants and hit classification
// Fixed ten-stage pipeline that never stalls: quarter-wave sine of the
// heading, the three cross products, the strict hit test, then magnitudes.
// ----------------------------------------------------------------------------
module rsi_front
    import rsi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic signed [COORD_W-1:0] seg_ax,
    input  logic signed [COORD_W-1:0] seg_ay,
    input  logic signed [COORD_W-1:0] seg_bx,
    input  logic signed [COORD_W-1:0] seg_by,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic [HEAD_W-1:0]         heading,
    output logic                      push,
    output qitem_t                    push_data
);

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [DIFF_W-1:0]  y12;
        logic signed [DIFF_W-1:0]  x12;
        logic signed [DIFF_W-1:0]  y13;
        logic signed [DIFF_W-1:0]  x13;
        logic signed [DIFF_W-1:0]  ddx;
        logic signed [DIFF_W-1:0]  ddy;
    } geo_t;

    logic   vld_reg [0:9];
    geo_t   geo_reg [0:8];
    quad_t  quad_reg [0:5];
    logic [16:0] x_reg [0:4][2];
    logic [16:0] xsq_reg [1:3][2];
    logic [12:0] p1_reg [2];
    logic [15:0] p2_reg [2];
    logic [16:0] p3_reg [2];
    logic [14:0] sn_reg [2];
    logic signed [DIR_W-1:0] dx_reg;
    logic signed [DIR_W-1:0] dy_reg;
    logic signed [DET_W-1:0] y12dx_reg, x12dy_reg, y13dx_reg, x13dy_reg;
    logic signed [UN_W-1:0]  y12x13_reg, x12y13_reg;
    logic signed [DET_W-1:0] den_reg, tn_reg;
    logic signed [UN_W-1:0]  un_reg;
    qitem_t q_reg;

    geo_t        geo_c;
    logic [16:0] xa_c;
    logic [33:0] sq_c [2];
    logic [25:0] m7_c [2];
    logic [29:0] m5_c [2];
    logic [32:0] m3_c [2];
    logic [33:0] m1_c [2];
    logic [15:0] s_c [2];
    logic signed [DIR_W-1:0] sa_c, sb_c;
    logic        hit_c;
    logic [DET_W-1:0] den_mag_c, tn_mag_c;
    logic [DIFF_W-1:0] ax_c, ay_c;

    always_comb
    begin
        geo_c.x1  = seg_ax;
        geo_c.y1  = seg_ay;
        geo_c.y12 = DIFF_W'(seg_ay) - DIFF_W'(seg_by);
        geo_c.x12 = DIFF_W'(seg_ax) - DIFF_W'(seg_bx);
        geo_c.y13 = DIFF_W'(seg_ay) - DIFF_W'(origin_y);
        geo_c.x13 = DIFF_W'(seg_ax) - DIFF_W'(origin_x);
        geo_c.ddx = DIFF_W'(seg_bx) - DIFF_W'(seg_ax);
        geo_c.ddy = DIFF_W'(seg_by) - DIFF_W'(seg_ay);
        xa_c = 17'(heading[HEADING_BITS-3:0]) << SINE_SHIFT;
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            sq_c[i] = 34'(x_reg[0][i]) * 34'(x_reg[0][i]);
            m7_c[i] = 26'(xsq_reg[1][i]) * 26'(SIN_C7);
            m5_c[i] = 30'(xsq_reg[2][i]) * 30'(p1_reg[i]);
            m3_c[i] = 33'(xsq_reg[3][i]) * 33'(p2_reg[i]);
            m1_c[i] = 34'(x_reg[4][i]) * 34'(p3_reg[i]);
            s_c[i]  = 16'(m1_c[i] >> 18);
        end
        sa_c = $signed({1'b0, sn_reg[0]});
        sb_c = $signed({1'b0, sn_reg[1]});
    end

    // strict crossing: 0 < t < 1 on the segment, u > 0 along the ray
    always_comb
    begin
        hit_c = 1'b0;
        if (den_reg > 0)
        begin
            hit_c = (tn_reg > 0) && (tn_reg < den_reg) && (un_reg > 0);
        end
        else if (den_reg < 0)
        begin
            hit_c = (tn_reg < 0) && (tn_reg > den_reg) && (un_reg < 0);
        end
        den_mag_c = den_reg[DET_W-1] ? DET_W'(-den_reg) : DET_W'(den_reg);
        tn_mag_c  = tn_reg[DET_W-1] ? DET_W'(-tn_reg) : DET_W'(tn_reg);
        ax_c = geo_reg[8].ddx[DIFF_W-1] ? DIFF_W'(-geo_reg[8].ddx)
                                        : DIFF_W'(geo_reg[8].ddx);
        ay_c = geo_reg[8].ddy[DIFF_W-1] ? DIFF_W'(-geo_reg[8].ddy)
                                        : DIFF_W'(geo_reg[8].ddy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 10; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= take;
            for (int k = 1; k < 10; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        geo_reg[0]  <= geo_c;
        quad_reg[0] <= quad_t'(heading[HEADING_BITS-1:HEADING_BITS-2]);
        x_reg[0][0] <= xa_c;
        x_reg[0][1] <= 17'h10000 - xa_c;
        for (int k = 1; k < 9; k++)
        begin
            geo_reg[k] <= geo_reg[k-1];
        end
        for (int k = 1; k < 6; k++)
        begin
            quad_reg[k] <= quad_reg[k-1];
        end
        for (int i = 0; i < 2; i++)
        begin
            for (int k = 1; k < 5; k++)
            begin
                x_reg[k][i] <= x_reg[k-1][i];
            end
            xsq_reg[1][i] <= sq_c[i][32:16];
            xsq_reg[2][i] <= xsq_reg[1][i];
            xsq_reg[3][i] <= xsq_reg[2][i];
            p1_reg[i] <= 13'(SIN_C5) - 13'(m7_c[i] >> 16);
            p2_reg[i] <= 16'(SIN_C3) - 16'(m5_c[i] >> 16);
            p3_reg[i] <= 17'(SIN_C1) - 17'(m3_c[i] >> 16);
            sn_reg[i] <= (s_c[i] > 16'(DIR_ONE)) ? 15'(DIR_ONE) : 15'(s_c[i]);
        end
        unique case (quad_reg[5])
            QUAD_0:
            begin
                dx_reg <= sb_c;
                dy_reg <= sa_c;
            end
            QUAD_1:
            begin
                dx_reg <= -sa_c;
                dy_reg <= sb_c;
            end
            QUAD_2:
            begin
                dx_reg <= -sb_c;
                dy_reg <= -sa_c;
            end
            QUAD_3:
            begin
                dx_reg <= sa_c;
                dy_reg <= -sb_c;
            end
            default:
            begin
                dx_reg <= sb_c;
                dy_reg <= sa_c;
            end
        endcase
        y12dx_reg  <= DET_W'(geo_reg[6].y12) * DET_W'(dx_reg);
        x12dy_reg  <= DET_W'(geo_reg[6].x12) * DET_W'(dy_reg);
        y13dx_reg  <= DET_W'(geo_reg[6].y13) * DET_W'(dx_reg);
        x13dy_reg  <= DET_W'(geo_reg[6].x13) * DET_W'(dy_reg);
        y12x13_reg <= UN_W'(geo_reg[6].y12) * UN_W'(geo_reg[6].x13);
        x12y13_reg <= UN_W'(geo_reg[6].x12) * UN_W'(geo_reg[6].y13);
        den_reg <= y12dx_reg - x12dy_reg;
        tn_reg  <= y13dx_reg - x13dy_reg;
        un_reg  <= y12x13_reg - x12y13_reg;
        q_reg.hit  <= hit_c;
        q_reg.x1   <= geo_reg[8].x1;
        q_reg.y1   <= geo_reg[8].y1;
        q_reg.ax   <= ax_c;
        q_reg.ay   <= ay_c;
        q_reg.negx <= geo_reg[8].ddx[DIFF_W-1];
        q_reg.negy <= geo_reg[8].ddy[DIFF_W-1];
        q_reg.b    <= MAG_W'(tn_mag_c);
        q_reg.c    <= MAG_W'(den_mag_c);
    end

    assign push      = vld_reg[9];
    assign push_data = q_reg;

endmodule

// ----- rtl/rsi_fifo.sv -----
// ----------------------------------------------------------------------------
// rsi_fifo: queue between front and back
// Sixteen-entry first-in first-out buffer of classified segments, with the
// head beat prefetched into an output register.
// ----------------------------------------------------------------------------
module rsi_fifo
    import rsi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qitem_t wdata,
    input  logic   pop,
    output qitem_t rdata,
    output logic   empty
);

    qitem_t mem [FIFO_DEPTH];
    qitem_t rdata_reg;
    logic [FIFO_AW-1:0] wptr_reg, rptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               rvalid_reg;
    logic               load;

    // refill the head register when it is free or being taken
    assign load       = (count_reg != '0) && (!rvalid_reg || pop);
    assign count_next = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (load)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (load)
            begin
                rvalid_reg <= 1'b1;
            end
            else if (pop)
            begin
                rvalid_reg <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
        if (load)
        begin
            rdata_reg <= mem[rptr_reg];
        end
    end

    assign rdata = rdata_reg;
    assign empty = !rvalid_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !load && count_reg == (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("queue written while full");

    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rvalid_reg)
        else $error("queue popped while empty");

endmodule

// ----- rtl/rsi_back.sv -----
// ----------------------------------------------------------------------------
// rsi_back: intersection point divider and output register
// One quotient bit per stage for both coordinates, then offset, saturate
// and hold the result beat until it is taken.
// ----------------------------------------------------------------------------
module rsi_back
    import rsi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  qitem_t                     head,
    input  logic                       fifo_empty,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic signed [COORD_W-1:0]  hit_x,
    output logic signed [COORD_W-1:0]  hit_y
);

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [DIFF_W-1:0]         ax;
        logic [DIFF_W-1:0]         ay;
        logic                      negx;
        logic                      negy;
        logic [MAG_W-1:0]          b;
        logic [MAG_W-1:0]          c;
        logic [MAG_W-1:0]          rx;
        logic [MAG_W-1:0]          ry;
        logic [DIFF_W-1:0]         qx;
        logic [DIFF_W-1:0]         qy;
    } bk_t;

    bk_t  st_reg  [0:DIFF_W];
    logic vld_reg [0:DIFF_W];
    bk_t  step_c  [1:DIFF_W];
    bk_t  load_c;
    logic en;
    logic out_valid_reg, hit_reg;
    logic signed [COORD_W-1:0] hit_x_reg, hit_y_reg;
    logic signed [26:0] px_c, py_c;

    function automatic logic signed [COORD_W-1:0] pt_sat(input logic signed [26:0] v);
        logic signed [COORD_W-1:0] res;
        priority if (v > PT_MAX)
        begin
            res = COORD_W'(PT_MAX);
        end
        else if (v < PT_MIN)
        begin
            res = COORD_W'(PT_MIN);
        end
        else
        begin
            res = COORD_W'(v);
        end
        return res;
    endfunction

    // advance whenever the output register is free or being emptied
    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && !fifo_empty;

    always_comb
    begin
        load_c.hit  = head.hit;
        load_c.x1   = head.x1;
        load_c.y1   = head.y1;
        load_c.ax   = head.ax;
        load_c.ay   = head.ay;
        load_c.negx = head.negx;
        load_c.negy = head.negy;
        load_c.b    = head.b;
        load_c.c    = head.c;
        load_c.rx   = '0;
        load_c.ry   = '0;
        load_c.qx   = '0;
        load_c.qy   = '0;
    end

    for (genvar k = 0; k < DIFF_W; k++)
    begin : g_div
        dstep_t sx, sy;
        assign sx = div_step(st_reg[k].rx, st_reg[k].ax[DIFF_W-1-k], st_reg[k].b, st_reg[k].c);
        assign sy = div_step(st_reg[k].ry, st_reg[k].ay[DIFF_W-1-k], st_reg[k].b, st_reg[k].c);
        always_comb
        begin
            step_c[k+1]    = st_reg[k];
            step_c[k+1].rx = sx.r;
            step_c[k+1].ry = sy.r;
            step_c[k+1].qx = {st_reg[k].qx[DIFF_W-2:0], 1'b0} + DIFF_W'(sx.inc);
            step_c[k+1].qy = {st_reg[k].qy[DIFF_W-2:0], 1'b0} + DIFF_W'(sy.inc);
        end
    end

    always_comb
    begin
        px_c = 27'(st_reg[DIFF_W].x1) + (st_reg[DIFF_W].negx
               ? -$signed({2'b00, st_reg[DIFF_W].qx}) : $signed({2'b00, st_reg[DIFF_W].qx}));
        py_c = 27'(st_reg[DIFF_W].y1) + (st_reg[DIFF_W].negy
               ? -$signed({2'b00, st_reg[DIFF_W].qy}) : $signed({2'b00, st_reg[DIFF_W].qy}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIFF_W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= pop;
            for (int k = 1; k <= DIFF_W; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_valid_reg <= vld_reg[DIFF_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= load_c;
            for (int k = 1; k <= DIFF_W; k++)
            begin
                st_reg[k] <= step_c[k];
            end
            hit_reg   <= st_reg[DIFF_W].hit;
            hit_x_reg <= st_reg[DIFF_W].hit ? pt_sat(px_c) : '0;
            hit_y_reg <= st_reg[DIFF_W].hit ? pt_sat(py_c) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_x     = hit_x_reg;
    assign hit_y     = hit_y_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> (hit_x_reg == '0 && hit_y_reg == '0))
        else $error("miss beat carries a nonzero point");

endmodule

// ----- rtl/ray_segment_intersection_top.sv -----
// ----------------------------------------------------------------------------
// ray_segment_intersection_top: ray against wall segment test
// Configured ray, one segment per input beat, one result beat per segment.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall  | seg_ax, seg_ay, seg_bx, seg_by
//  out     | out       | out_valid / out_stall| hit, hit_x, hit_y
//
//  One segment per cycle sustained while neither stall is raised; the path is 10
//  front stages, the queue's store and head register, 26 divider stages and
//  the output register.
//  The rate is set by the front pipeline and the one-bit-per-stage divider.
//  rst_n clears all valid state and the ray registers to zero.
//  in_stall rises when 16 beats sit in the front and the queue together.
//  out_stall freezes the divider; the front keeps draining into the queue.
// ----------------------------------------------------------------------------
module ray_segment_intersection_top
    import rsi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] seg_ax,
    input  logic signed [COORD_W-1:0] seg_ay,
    input  logic signed [COORD_W-1:0] seg_bx,
    input  logic signed [COORD_W-1:0] seg_by,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic signed [COORD_W-1:0] hit_x,
    output logic signed [COORD_W-1:0] hit_y
);

    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic [HEAD_W-1:0]         heading_reg;
    logic [FIFO_AW:0]          total_reg, total_next;
    logic   take, push, pop, fifo_empty;
    qitem_t push_data, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            heading_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                CFG_HEADING:  heading_reg  <= cfg_data[HEAD_W-1:0];
                default:      ;
            endcase
        end
    end

    // count beats held by the front and the queue so the queue never fills
    assign in_stall   = (total_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign take       = in_valid && !in_stall;
    assign total_next = total_reg + (FIFO_AW+1)'(take) - (FIFO_AW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    rsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .seg_ax    (seg_ax),
        .seg_ay    (seg_ay),
        .seg_bx    (seg_bx),
        .seg_by    (seg_by),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .heading   (heading_reg),
        .push      (push),
        .push_data (push_data)
    );

    rsi_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .pop   (pop),
        .rdata (head),
        .empty (fifo_empty)
    );

    rsi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .hit_x      (hit_x),
        .hit_y      (hit_y)
    );

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("beat count above queue depth");

    a_pop_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (total_reg != '0))
        else $error("queue popped with no beat in flight");

endmodule

// ----- sim/ray_segment_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_segment_checker: result predictor and comparator
// Mirrors the ray registers from the config port, predicts hit and point for
// each accepted segment beat and compares each result beat in order.
// ----------------------------------------------------------------------------
module ray_segment_checker
    import rsi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic signed [COORD_W-1:0] seg_ax,
    input  logic signed [COORD_W-1:0] seg_ay,
    input  logic signed [COORD_W-1:0] seg_bx,
    input  logic signed [COORD_W-1:0] seg_by,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      hit,
    input  logic signed [COORD_W-1:0] hit_x,
    input  logic signed [COORD_W-1:0] hit_y,
    output int                        fail_count,
    output int                        pending
);

    typedef struct {
        logic                      hit;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } crossing_t;

    crossing_t               crossing_q[$];
    logic signed [COORD_W-1:0] origin_x, origin_y;
    logic [HEAD_W-1:0]         heading;

    assign pending = crossing_q.size();

    function automatic longint quarter_wave(input longint x);
        longint x2, p, s;
        x2 = (x * x) >>> 16;
        p  = 5223 - ((x2 * 307) >>> 16);
        p  = 42334 - ((x2 * p) >>> 16);
        p  = 102944 - ((x2 * p) >>> 16);
        s  = ((x * p) >>> 16) >>> 2;
        if (s > 16384)
            s = 16384;
        return s;
    endfunction

    function automatic longint iabs(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_point(input longint a,
        input longint diff, input longint tn, input longint den);
        longint q, v;
        logic   neg;
        q   = (iabs(tn) * iabs(diff)) / iabs(den);
        neg = ((tn < 0) != (diff < 0)) != (den < 0);
        if (diff == 0 || tn == 0)
            neg = 1'b0;
        v = a + (neg ? -q : q);
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[COORD_W-1:0];
    endfunction

    function automatic crossing_t predict_crossing(input longint x1, input longint y1,
        input longint x2, input longint y2);
        crossing_t c;
        longint    r, sa, sb, dx, dy, den, tn, un, x3, y3;
        logic [1:0] quad;
        x3   = origin_x;
        y3   = origin_y;
        quad = heading[HEAD_W-1 -: 2];
        r    = longint'(heading[HEAD_W-3:0]) << SINE_SHIFT;
        sa   = quarter_wave(r);
        sb   = quarter_wave(65536 - r);
        case (quad_t'(quad))
            QUAD_0:  begin dx = sb;  dy = sa;  end
            QUAD_1:  begin dx = -sa; dy = sb;  end
            QUAD_2:  begin dx = -sb; dy = -sa; end
            default: begin dx = sa;  dy = -sb; end
        endcase
        den = (y1 - y2) * dx - (x1 - x2) * dy;
        tn  = (y1 - y3) * dx - (x1 - x3) * dy;
        un  = (y1 - y2) * (x1 - x3) - (x1 - x2) * (y1 - y3);
        c.hit = 1'b0;
        if (den > 0)
            c.hit = tn > 0 && tn < den && un > 0;
        else if (den < 0)
            c.hit = tn < 0 && tn > den && un < 0;
        c.x = '0;
        c.y = '0;
        if (c.hit)
        begin
            c.x = clamp_point(x1, x2 - x1, tn, den);
            c.y = clamp_point(y1, y2 - y1, tn, den);
        end
        return c;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        crossing_t want;
        if (!rst_n)
        begin
            origin_x   <= '0;
            origin_y   <= '0;
            heading    <= '0;
            fail_count <= 0;
            crossing_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (crossing_q.size() == 0)
                    report("unexpected beat", hit, 0);
                else
                begin
                    want = crossing_q.pop_front();
                    if (hit !== want.hit)
                        report("hit", hit, want.hit);
                    if (hit_x !== want.x)
                        report("hit_x", hit_x, want.x);
                    if (hit_y !== want.y)
                        report("hit_y", hit_y, want.y);
                end
            end
            if (in_valid && !in_stall)
                crossing_q.push_back(predict_crossing(seg_ax, seg_ay, seg_bx, seg_by));
            if (cfg_we)
                case (cfg_idx_t'(cfg_index))
                    CFG_ORIGIN_X: origin_x <= cfg_data;
                    CFG_ORIGIN_Y: origin_y <= cfg_data;
                    CFG_HEADING:  heading  <= cfg_data[HEAD_W-1:0];
                    default: ;
                endcase
        end
    end

endmodule

// ----- sim/ray_segment_intersection_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_segment_intersection_top_tb: stimulus and verdict
// Sweeps ray settings, sends directed and random segments (mostly ones that
// straddle the x axis) under varied idling, and leaves checking to the checker.
// ----------------------------------------------------------------------------
module ray_segment_intersection_top_tb;
    import rsi_pkg::*;

    localparam int WATCHDOG = 20000;

    logic clk, rst_n, cfg_we, in_valid, in_stall, out_valid, out_stall, hit;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic signed [COORD_W-1:0] seg_ax, seg_ay, seg_bx, seg_by, hit_x, hit_y;
    int fail_count, pending, quiet, send_idle_pct, recv_idle_pct;

    ray_segment_intersection_top u_dut (.*);

    ray_segment_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCHDOG)
        begin
            $display("[ray_segment_intersection_top] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_ray(input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy,
                           input logic [HEAD_W-1:0] hd);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_HEADING, CFG_W'(hd));
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    // send one segment; valid stays up across back-to-back beats
    task automatic send_segment(input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
                                input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        seg_ax <= ax;
        seg_ay <= ay;
        seg_bx <= bx;
        seg_by <= by;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(input int span);
        case ($urandom_range(7))
            0:       return COORD_W'($urandom);
            1:       return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: return COORD_W'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    // segment straddling the x axis most of the time
    task automatic random_segment(input int span);
        logic [COORD_W-1:0] ax, ay, bx, by;
        ax = rand_coord(span);
        ay = rand_coord(span);
        bx = $urandom_range(3) == 0 ? ax : rand_coord(span);
        by = $urandom_range(3) == 0 ? ay : COORD_W'(-$signed(ay));
        send_segment(ax, ay, bx, by);
    endtask

    initial
    begin
        int span;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        seg_ax = '0;
        seg_ay = '0;
        seg_bx = '0;
        seg_by = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset ray along +x
        send_segment(24'd1000, -24'sd1000, 24'd1000, 24'd1000);
        send_segment(24'd1000, 24'd0, 24'd1000, 24'd1000);       // endpoint touch
        send_segment(-24'sd1000, -24'sd500, -24'sd1000, 24'd500); // behind origin
        send_segment(24'd10, 24'd5, 24'd500, 24'd5);              // parallel
        send_segment(24'd77, 24'd77, 24'd77, 24'd77);             // degenerate
        send_segment(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
        send_segment(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
        send_segment(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000);
        send_segment(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
        in_valid <= 1'b0;
        drain();
        set_ray(24'h7FFFFF, 24'h800000, 12'd1536);
        send_segment(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
        send_segment(24'h800000, 24'h000000, 24'h7FFFFF, 24'h7FFFFF);
        send_segment(24'h7FFFFF, 24'h000000, 24'h800000, 24'h7FFFFF);
        in_valid <= 1'b0;
        drain();
        set_ray(24'h800000, 24'h7FFFFF, 12'hFFF);
        send_segment(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
        send_segment(24'h000000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
        send_segment(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000);
        in_valid <= 1'b0;
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            send_idle_pct = phase < 4 ? 34 : (phase < 8 ? 71 : 0);
            recv_idle_pct = phase < 4 ? 71 : (phase < 8 ? 34 : 0);
            span = phase % 3 == 0 ? 8388607 : (phase % 3 == 1 ? 4096 : 200000);
            case (phase % 4)
                0:       set_ray('0, '0, 12'd0);
                1:       set_ray(24'h7FFFFF, 24'h7FFFFF, 12'hFFF);
                2:       set_ray(24'h800000, 24'h800000, 12'd2048);
                default: set_ray(CFG_W'($urandom), CFG_W'($urandom), HEAD_W'($urandom));
            endcase
            for (int i = 0; i < 85; i++)
            begin
                random_segment(span);
                if (i == 40 && phase == 2)
                begin
                    // hold off until the pipe is empty
                    in_valid <= 1'b0;
                    while (pending != 0)
                        @(posedge clk);
                end
            end
            in_valid <= 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("[ray_segment_intersection_top] OK");
        else
            $display("[ray_segment_intersection_top] ERROR");
        $finish;
    end

endmodule
